// ===== sv/sle_pkg.sv =====
package sle_pkg;

  localparam int LINE_MAX = 20;
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int LEN_SAT  = 31;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_BS = 8'd8;
  localparam logic [BYTE_W-1:0] BYTE_SP = 8'd32;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Access to the line store from the controller.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

  // Line length as it travels in an end marker, saturated to the field.
  function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] n);
    int v;
    v = int'(n);
    return (v > LEN_SAT) ? LEN_W'(LEN_SAT) : LEN_W'(v);
  endfunction

endpackage

// ===== sv/sle_line_ram.sv =====
module sle_line_ram (
  input  logic                           clk,
  input  sle_pkg::ram_req_t              req,
  output logic [sle_pkg::BYTE_W-1:0]     rdata
);

  logic [sle_pkg::BYTE_W-1:0] mem [sle_pkg::LINE_MAX];
  logic [sle_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sle_ctrl.sv =====
module sle_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sle_pkg::BYTE_W-1:0]     in_byte,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sle_pkg::BYTE_W-1:0]     out_byte,
  output sle_pkg::kind_t                 out_kind,
  output logic [sle_pkg::LEN_W-1:0]      out_len,
  output logic                           out_last,
  output sle_pkg::ram_req_t              ram_req,
  input  logic [sle_pkg::BYTE_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {S_IDLE, S_SP, S_BS, S_RD, S_CH, S_END} state_t;

  state_t                    state_r;
  logic [sle_pkg::CNT_W-1:0] count_r;
  logic [sle_pkg::CNT_W-1:0] len_r;
  logic [sle_pkg::CNT_W-1:0] idx_r;
  logic [sle_pkg::CNT_W-1:0] idx_nxt;
  logic                      out_valid_r;
  logic [sle_pkg::BYTE_W-1:0] out_byte_r;
  sle_pkg::kind_t            out_kind_r;
  logic [sle_pkg::LEN_W-1:0] out_len_r;
  logic                      out_last_r;

  logic can_load;
  logic out_load;
  logic in_acc;
  logic is_cr;
  logic is_bs;
  logic has_room;

  assign can_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && can_load;
  assign in_acc    = in_tvalid && in_tready;
  assign is_cr     = (in_byte == sle_pkg::BYTE_CR);
  assign is_bs     = (in_byte == sle_pkg::BYTE_BS);
  assign has_room  = (count_r < sle_pkg::CNT_W'(sle_pkg::LINE_MAX));
  assign idx_nxt   = idx_r + sle_pkg::CNT_W'(1);
  assign out_load  = in_acc || ((state_r inside {S_SP, S_BS, S_CH, S_END}) && can_load);

  // Writes happen only on an accepted beat in idle and reads only later in a
  // carriage-return walk, so the two never touch one entry in one cycle.
  always_comb begin
    ram_req.we    = in_acc && !is_cr && !is_bs && has_room;
    ram_req.re    = (state_r == S_RD);
    ram_req.addr  = (state_r == S_RD) ? idx_r[sle_pkg::ADDR_W-1:0]
                                      : count_r[sle_pkg::ADDR_W-1:0];
    ram_req.wdata = in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= in_byte;
            out_kind_r  <= sle_pkg::KIND_ECHO;
            out_len_r   <= '0;
            out_last_r  <= !(is_cr || (is_bs && (count_r != '0)));
            if (is_cr) begin
              len_r      <= count_r;
              idx_r      <= '0;
              count_r    <= '0;
              state_r    <= (count_r == '0) ? S_END : S_RD;
            end else if (is_bs) begin
              if (count_r != '0) begin
                count_r    <= count_r - sle_pkg::CNT_W'(1);
                state_r    <= S_SP;
              end
            end else if (has_room) begin
              count_r <= count_r + sle_pkg::CNT_W'(1);
            end
          end
        end
        S_SP: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= sle_pkg::BYTE_SP;
            out_kind_r  <= sle_pkg::KIND_ECHO;
            out_len_r   <= '0;
            out_last_r  <= 1'b0;
            state_r     <= S_BS;
          end
        end
        S_BS: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= sle_pkg::BYTE_BS;
            out_kind_r  <= sle_pkg::KIND_ECHO;
            out_len_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_CH;
        end
        S_CH: begin
          // The read data register holds until the next read is issued.
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= ram_rdata;
            out_kind_r  <= sle_pkg::KIND_CHAR;
            out_len_r   <= '0;
            out_last_r  <= 1'b0;
            idx_r       <= idx_nxt;
            state_r     <= (idx_nxt == len_r) ? S_END : S_RD;
          end
        end
        S_END: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= '0;
            out_kind_r  <= sle_pkg::KIND_END;
            out_len_r   <= sle_pkg::len_field(len_r);
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_kind   = out_kind_r;
  assign out_len    = out_len_r;
  assign out_last   = out_last_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sle_pkg::CNT_W'(sle_pkg::LINE_MAX))
    else $error("character count beyond line capacity");

  a_walk_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CH) |-> (idx_r < len_r))
    else $error("line walk index beyond stored length");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_IDLE && !ram_req.re))
    else $error("line store written outside idle");

  a_cr_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_cr) |=> (out_valid_r && out_kind_r == sle_pkg::KIND_ECHO
                           && !out_last_r && count_r == '0))
    else $error("carriage return echo not marked as leading beat");

endmodule

// ===== sv/serial_line_editor_echo_top.sv =====
// The echo beat is presented in the cycle after the input beat is taken.
// A backspace on a non-empty line adds a space and a backspace to its echo; a
// carriage return adds each stored character, read from the line store, then an
// end marker. Stalls hold each step, and no new byte is taken until all is sent.
// Reset (rst_n low, synchronous) empties the line and the output register; the
// line store itself keeps its contents and needs no clearing pass.
module serial_line_editor_echo_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [12:8] line_length, rest zero
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast
);

  sle_pkg::ram_req_t              ram_req;
  logic [sle_pkg::BYTE_W-1:0]     ram_rdata;
  logic [sle_pkg::BYTE_W-1:0]     out_byte;
  sle_pkg::kind_t                 out_kind;
  logic [sle_pkg::LEN_W-1:0]      out_len;

  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_len    (out_len),
    .out_last   (out_tlast),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  sle_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_tdata = {3'b000, out_len, out_byte};
  assign out_tuser = out_kind;

endmodule
